FILE: hdl/site_pattern_compressor_top_macros.svh
`ifndef SITE_PATTERN_COMPRESSOR_TOP_MACROS_SVH
`define SITE_PATTERN_COMPRESSOR_TOP_MACROS_SVH

// Checks sampled on clk, off while rst_n is low.

// Condition holds at every edge.
`define SPC_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SPC_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SPC_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/spc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

  localparam int SYM_W    = 5;
  localparam int TAXA_W   = 7;
  localparam int WEIGHT_W = 24;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 9;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

  // register map: index = paddr[3:2]
  localparam logic [1:0] REG_TAXA  = 2'd0;
  localparam logic [1:0] REG_UNAMB = 2'd1;
  localparam logic [1:0] REG_GAP   = 2'd2;

  localparam logic [TAXA_W-1:0] TAXA_RST  = 7'd64;
  localparam logic [SYM_W-1:0]  UNAMB_RST = 5'd4;
  localparam logic [SYM_W-1:0]  GAP_RST   = 5'd17;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCMP,
    ST_WRD,
    ST_WUPD,
    ST_CRD,
    ST_CWR,
    ST_DONE
  } spc_state_t;

  // column tracker status for the symbol being pushed this cycle
  typedef struct packed {
    logic done;
    logic constant;
  } spc_col_stat_t;

endpackage

`default_nettype wire

FILE: hdl/spc_col_track.sv
`timescale 1ns / 1ps
`default_nettype none

module spc_col_track #(
  parameter int MAX_TAXA = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic [spc_pkg::SYM_W-1:0]           symbol,
  input  logic [spc_pkg::TAXA_W-1:0]          taxa_in_use,
  input  logic [spc_pkg::SYM_W-1:0]           unambiguous_max,
  input  logic [spc_pkg::SYM_W-1:0]           gap_code,
  input  logic [$clog2(MAX_TAXA)-1:0]         rd_idx,
  output logic [spc_pkg::SYM_W-1:0]           rd_data,
  output logic [$clog2(MAX_TAXA+1)-1:0]       n_eff,
  output spc_pkg::spc_col_stat_t              stat
);
  import spc_pkg::*;

  localparam int TW = $clog2(MAX_TAXA);
  localparam int CW = $clog2(MAX_TAXA + 1);
  localparam int XW = (CW > TAXA_W) ? CW : TAXA_W;

  logic [SYM_W-1:0] col_mem [MAX_TAXA];

  logic [TW-1:0]    pos_r, pos_nxt;
  logic [SYM_W-1:0] first_r, first_nxt;
  logic             seen_r, seen_nxt;
  logic             var_r, var_nxt;

  logic [XW-1:0]    taxa_x;
  logic [XW-1:0]    n_x;
  logic             amb;
  logic             var_now;
  logic             last;

  // 0 acts as 1, anything above MAX_TAXA as MAX_TAXA
  always_comb begin
    taxa_x = XW'(taxa_in_use);
    if (taxa_in_use == '0) begin
      n_x = XW'(1);
    end else if (taxa_x > XW'(MAX_TAXA)) begin
      n_x = XW'(MAX_TAXA);
    end else begin
      n_x = taxa_x;
    end
  end

  assign n_eff = CW'(n_x);

  assign amb     = (symbol > unambiguous_max) && (symbol != gap_code);
  assign var_now = var_r | (seen_r & ~amb & (first_r != symbol));
  assign last    = (CW'(pos_r) + CW'(1)) >= n_eff;

  assign stat.done     = push & last;
  assign stat.constant = ~var_now;

  always_comb begin
    pos_nxt   = pos_r;
    first_nxt = first_r;
    seen_nxt  = seen_r;
    var_nxt   = var_r;
    if (push) begin
      if (last) begin
        pos_nxt   = '0;
        first_nxt = '0;
        seen_nxt  = 1'b0;
        var_nxt   = 1'b0;
      end else begin
        pos_nxt = pos_r + TW'(1);
        var_nxt = var_now;
        if (!amb && !seen_r) begin
          seen_nxt  = 1'b1;
          first_nxt = symbol;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      first_r <= '0;
      seen_r  <= 1'b0;
      var_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      first_r <= first_nxt;
      seen_r  <= seen_nxt;
      var_r   <= var_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      col_mem[pos_r] <= symbol;
    end
    rd_data <= col_mem[rd_idx];
  end

endmodule

`default_nettype wire

FILE: hdl/site_pattern_compressor_top.sv
// Site pattern compressor. Takes alignment columns one symbol word at a time
// (in_cmd = 0) and, when a column of taxa_in_use symbols is complete, returns
// one result word: constant columns are flagged and dropped, other columns are
// matched against a table of unique patterns whose weight is bumped
// (saturating at 2^24-1), or appended with weight 1, or flagged table_full.
// in_cmd = 1 empties the table and returns nothing. For a column that is not
// constant, one compare unit walks the stored patterns in order, comparing
// symbol by symbol and stopping at the first mismatch in each pattern; a
// match is followed by a weight read-modify-write, and a new pattern has its
// n symbols copied into the store (n = effective taxa count). The pattern
// store is one MAX_PATTERNS*MAX_TAXA memory with one read and one write port,
// so the search time grows with the number of patterns held. in_stall is
// high while a column end is being processed. A finished result waits in the
// output register while the next symbols are taken. No clearing pass after
// reset.
`timescale 1ns / 1ps
`default_nettype none

`include "site_pattern_compressor_top_macros.svh"

module site_pattern_compressor_top #(
  parameter int MAX_TAXA     = 64,
  parameter int MAX_PATTERNS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // symbol input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [spc_pkg::SYM_W-1:0]     in_symbol,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_column_constant,
  output logic                          out_new_pattern,
  output logic [spc_pkg::INDEX_W-1:0]   out_pattern_index,
  output logic [spc_pkg::WEIGHT_W-1:0]  out_pattern_weight,
  output logic [spc_pkg::COUNT_W-1:0]   out_pattern_count,
  output logic                          out_table_full,
  // APB config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import spc_pkg::*;

  localparam int TW     = $clog2(MAX_TAXA);
  localparam int CW     = $clog2(MAX_TAXA + 1);
  localparam int PW     = $clog2(MAX_PATTERNS);
  localparam int CNTW   = $clog2(MAX_PATTERNS + 1);
  localparam int PDEPTH = MAX_PATTERNS * MAX_TAXA;
  localparam int PAW    = $clog2(PDEPTH);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [TAXA_W-1:0] taxa_r;
  logic [SYM_W-1:0]  unamb_r;
  logic [SYM_W-1:0]  gap_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taxa_r  <= TAXA_RST;
      unamb_r <= UNAMB_RST;
      gap_r   <= GAP_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TAXA:  taxa_r  <= pwdata[TAXA_W-1:0];
        REG_UNAMB: unamb_r <= pwdata[SYM_W-1:0];
        REG_GAP:   gap_r   <= pwdata[SYM_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TAXA:  prdata = 32'(taxa_r);
      REG_UNAMB: prdata = 32'(unamb_r);
      REG_GAP:   prdata = 32'(gap_r);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Column tracker: buffer, position, constant test
  // ---------------------------------------------------------------------------
  spc_state_t    state_r, state_nxt;
  logic          in_acc;
  logic          col_push;
  spc_col_stat_t col_stat;
  logic [SYM_W-1:0] col_q;
  logic [CW-1:0] n_eff;

  logic [TW-1:0] t_r, t_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign col_push = in_acc & (in_cmd == CMD_PUSH);

  spc_col_track #(
    .MAX_TAXA (MAX_TAXA)
  ) u_col (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (col_push),
    .symbol          (in_symbol),
    .taxa_in_use     (taxa_r),
    .unambiguous_max (unamb_r),
    .gap_code        (gap_r),
    .rd_idx          (t_r),
    .rd_data         (col_q),
    .n_eff           (n_eff),
    .stat            (col_stat)
  );

  // ---------------------------------------------------------------------------
  // Pattern store and weights
  // ---------------------------------------------------------------------------
  logic [SYM_W-1:0]    pat_mem [PDEPTH];
  logic [SYM_W-1:0]    pat_q_r;
  logic [PAW-1:0]      pat_addr;
  logic                pat_we;

  logic [WEIGHT_W-1:0] wgt_mem [MAX_PATTERNS];
  logic [WEIGHT_W-1:0] wgt_q_r;
  logic [WEIGHT_W-1:0] wgt_inc;
  logic [WEIGHT_W-1:0] wgt_wdata;
  logic                wgt_we;

  logic [PAW-1:0]  base_r, base_nxt;   // start of pattern p_r in the store
  logic [PW-1:0]   p_r, p_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            last_t;
  logic            last_p;
  logic            sym_eq;

  assign pat_addr = base_r + PAW'(t_r);
  assign last_t   = (CW'(t_r) + CW'(1)) >= n_eff;
  assign last_p   = (CNTW'(p_r) + CNTW'(1)) >= count_r;
  assign sym_eq   = (pat_q_r == col_q);
  assign wgt_inc  = (wgt_q_r == WEIGHT_MAX) ? WEIGHT_MAX : wgt_q_r + WEIGHT_W'(1);
  assign pat_we   = (state_r == ST_CWR);
  assign wgt_we   = (state_r == ST_WUPD) || ((state_r == ST_CWR) && last_t);
  assign wgt_wdata = (state_r == ST_WUPD) ? wgt_inc : WEIGHT_W'(1);

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_addr] <= col_q;
    end
    pat_q_r <= pat_mem[pat_addr];
  end

  always_ff @(posedge clk) begin
    if (wgt_we) begin
      wgt_mem[p_r] <= wgt_wdata;
    end
    wgt_q_r <= wgt_mem[p_r];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  // pending result, handed to the output register in ST_DONE
  logic                res_cc_r, res_cc_nxt;
  logic                res_np_r, res_np_nxt;
  logic                res_full_r, res_full_nxt;
  logic [PW-1:0]       res_idx_r, res_idx_nxt;
  logic [WEIGHT_W-1:0] res_w_r, res_w_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_load;
  logic                out_column_constant_r;
  logic                out_new_pattern_r;
  logic                out_table_full_r;
  logic [INDEX_W-1:0]  out_pattern_index_r;
  logic [WEIGHT_W-1:0] out_pattern_weight_r;
  logic [COUNT_W-1:0]  out_pattern_count_r;

  assign out_load      = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  always_comb begin
    state_nxt    = state_r;
    t_nxt        = t_r;
    p_nxt        = p_r;
    base_nxt     = base_r;
    count_nxt    = count_r;
    res_cc_nxt   = res_cc_r;
    res_np_nxt   = res_np_r;
    res_full_nxt = res_full_r;
    res_idx_nxt  = res_idx_r;
    res_w_nxt    = res_w_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_cmd == CMD_CLEAR)) begin
          count_nxt = '0;
        end else if (col_stat.done) begin
          t_nxt        = '0;
          p_nxt        = '0;
          base_nxt     = '0;
          res_cc_nxt   = 1'b0;
          res_np_nxt   = 1'b0;
          res_full_nxt = 1'b0;
          res_idx_nxt  = '0;
          res_w_nxt    = '0;
          if (col_stat.constant) begin
            res_cc_nxt = 1'b1;
            state_nxt  = ST_DONE;
          end else if (count_r == '0) begin
            // empty table: append straight away
            state_nxt = ST_CRD;
          end else begin
            state_nxt = ST_SRD;
          end
        end
      end
      ST_SRD: begin
        state_nxt = ST_SCMP;
      end
      ST_SCMP: begin
        if (sym_eq) begin
          if (last_t) begin
            state_nxt = ST_WRD;
          end else begin
            t_nxt     = t_r + TW'(1);
            state_nxt = ST_SRD;
          end
        end else begin
          t_nxt    = '0;
          base_nxt = base_r + PAW'(MAX_TAXA);
          if (last_p) begin
            if (count_r >= CNTW'(MAX_PATTERNS)) begin
              res_full_nxt = 1'b1;
              state_nxt    = ST_DONE;
            end else begin
              p_nxt     = PW'(count_r);
              state_nxt = ST_CRD;
            end
          end else begin
            p_nxt     = p_r + PW'(1);
            state_nxt = ST_SRD;
          end
        end
      end
      ST_WRD: begin
        state_nxt = ST_WUPD;
      end
      ST_WUPD: begin
        res_idx_nxt = p_r;
        res_w_nxt   = wgt_inc;
        state_nxt   = ST_DONE;
      end
      ST_CRD: begin
        state_nxt = ST_CWR;
      end
      ST_CWR: begin
        if (last_t) begin
          count_nxt   = count_r + CNTW'(1);
          res_np_nxt  = 1'b1;
          res_idx_nxt = p_r;
          res_w_nxt   = WEIGHT_W'(1);
          state_nxt   = ST_DONE;
        end else begin
          t_nxt     = t_r + TW'(1);
          state_nxt = ST_CRD;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    p_r        <= p_nxt;
    base_r     <= base_nxt;
    res_cc_r   <= res_cc_nxt;
    res_np_r   <= res_np_nxt;
    res_full_r <= res_full_nxt;
    res_idx_r  <= res_idx_nxt;
    res_w_r    <= res_w_nxt;
    if (out_load) begin
      out_column_constant_r <= res_cc_r;
      out_new_pattern_r     <= res_np_r;
      out_table_full_r      <= res_full_r;
      out_pattern_index_r   <= INDEX_W'(res_idx_r);
      out_pattern_weight_r  <= res_w_r;
      out_pattern_count_r   <= COUNT_W'(count_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_column_constant = out_column_constant_r;
  assign out_new_pattern     = out_new_pattern_r;
  assign out_table_full      = out_table_full_r;
  assign out_pattern_index   = out_pattern_index_r;
  assign out_pattern_weight  = out_pattern_weight_r;
  assign out_pattern_count   = out_pattern_count_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `SPC_ALWAYS(a_count_bound, count_r <= CNTW'(MAX_PATTERNS), "pattern count over table size")
  `SPC_SAME(a_out_kind, out_valid_r,
    $onehot0({out_column_constant_r, out_new_pattern_r, out_table_full_r}),
    "result word flags not exclusive")
  `SPC_SAME(a_new_weight, out_valid_r && out_new_pattern_r,
    out_pattern_weight_r == WEIGHT_W'(1), "new pattern weight not one")
  `SPC_NEXT(a_search_start,
    state_r == ST_IDLE && col_push && col_stat.done && !col_stat.constant && count_r != '0,
    state_r == ST_SRD, "variable column did not start the table search")

endmodule

`default_nettype wire
